### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the LRU key-value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checks a condition at every clock edge outside reset.
`define LKV_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("lkv assertion failed");
// Checks that a trigger is followed in the next cycle by a condition.
`define LKV_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("lkv assertion failed");
`else
`define LKV_ASSERT(label, clk, rst_n, cond)
`define LKV_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

### rtl/core/lkv_pkg.sv
// Package with the constants, types and helpers of the LRU key-value cache.
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int RANK_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef struct packed {
		logic                    action;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	// Clamp the capacity register into the range one to ENTRIES.
	function automatic count_t eff_capacity(logic [CAP_W-1:0] cap);
		count_t r;
		if (cap == '0) begin
			r = count_t'(1);
		end else if (int'(cap) > ENTRIES) begin
			r = count_t'(ENTRIES);
		end else begin
			r = count_t'(cap);
		end
		return r;
	endfunction

endpackage

### rtl/core/lkv_store.sv
// Entry registers with parallel key compare and LRU rank update.
module lkv_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  lkv_pkg::cmd_t                  cmd,
	input  lkv_pkg::count_t                eff_cap,
	output lkv_pkg::rsp_t                  rsp,
	output logic [lkv_pkg::ENTRIES-1:0]    entry_valid,
	output lkv_pkg::count_t                occ_count
);
	import lkv_pkg::*;

	logic signed [KEY_W-1:0] key_q [ENTRIES];
	logic signed [VAL_W-1:0] val_q [ENTRIES];
	logic [ENTRIES-1:0]      valid_q;
	rank_t                   rank_q [ENTRIES];
	count_t                  occ_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] victim_oh;
	logic [ENTRIES-1:0] tgt_oh;
	logic               hit;
	logic [VAL_W-1:0]   hit_val;
	rank_t              tgt_rank;
	rank_t              last_rank;
	logic               not_full;
	logic               do_move;
	logic               do_insert;
	logic               do_write;

	// Valid ranks are always distinct and dense, so the oldest entry holds occupancy minus one.
	assign last_rank = rank_t'(occ_q - count_t'(1));
	assign free_vec  = ~valid_q;
	assign free_oh   = free_vec & (~free_vec + ENTRIES'(1));
	assign not_full  = occ_q < eff_cap;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]     = valid_q[i] && (key_q[i] == cmd.key);
			victim_oh[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	always_comb begin
		hit_val = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_val = hit_val | (match[i] ? val_q[i] : '0);
		end
	end

	assign hit = |match;

	always_comb begin
		priority if (hit) begin
			tgt_oh = match;
		end else if (not_full) begin
			tgt_oh = free_oh;
		end else begin
			tgt_oh = victim_oh;
		end
	end

	always_comb begin
		tgt_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tgt_rank = tgt_rank | (tgt_oh[i] ? rank_q[i] : '0);
		end
	end

	assign do_write  = fire && (cmd.action == ACT_PUT);
	assign do_move   = fire && (hit || (cmd.action == ACT_PUT));
	assign do_insert = do_write && !hit && not_full;

	assign rsp.hit        = hit;
	assign rsp.read_value = hit ? hit_val : MISS_VALUE;
	assign entry_valid    = valid_q;
	assign occ_count      = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (do_move) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tgt_oh[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (valid_q[i] && (do_insert || (rank_q[i] < tgt_rank))) begin
					rank_q[i] <= rank_t'(rank_q[i] + 1'b1);
				end
			end
			if (do_insert) begin
				occ_q <= count_t'(occ_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tgt_oh[i]) begin
					key_q[i] <= cmd.key;
					val_q[i] <= cmd.value;
				end
			end
		end
	end

endmodule

### rtl/core/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// A get passes from the input register to the result register, which presents its result beat.
// Throughput: one item per cycle while the output side keeps up; a put never waits on it.
// The rate is set by the parallel key compare and the rank update done at the edge where an item fires.
// Reset (arst_n low, asynchronous) empties the cache and sets capacity to 16.
// Entry keys and values are not reset; they are only read once written.
`include "assert_macros.svh"

module lru_key_value_cache_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic signed [lkv_pkg::KEY_W-1:0]    key,
	input  logic signed [lkv_pkg::VAL_W-1:0]    value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [lkv_pkg::VAL_W-1:0]    read_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0]           cfg_data
);
	import lkv_pkg::*;

	// Capacity register. Writes must arrive only while the cache is idle; the
	// block does not enforce this, and the port can always take the beat.
	logic [CAP_W-1:0] cap_q;
	count_t           eff_cap;

	// Input register: the item waiting to be looked up.
	logic   valid_s1;
	cmd_t   cmd_s1;

	// Result register for get responses.
	logic   out_valid_q;
	rsp_t   rsp_q;

	// Lookup and update signals.
	logic   out_free;
	logic   store_fire;
	logic   in_take;
	rsp_t   store_rsp;
	logic [ENTRIES-1:0] entry_valid;
	count_t occ_count;

	assign cfg_ready = 1'b1;
	assign eff_cap   = eff_capacity(cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// The result register is free when empty or when its beat leaves now.
	// A put makes no result, so it never waits for the output side.
	assign out_free   = !out_valid_q || !out_stall;
	assign store_fire = valid_s1 && ((cmd_s1.action == ACT_PUT) || out_free);
	assign in_stall   = valid_s1 && !store_fire;
	assign in_take    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (store_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= '{action: action, key: key, value: value};
		end
	end

	// All entries are compared against the key in parallel, and the whole
	// state update for the item happens at the edge where it fires, so the
	// next item in the input register already sees the new recency order.
	lkv_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (store_fire),
		.cmd         (cmd_s1),
		.eff_cap     (eff_cap),
		.rsp         (store_rsp),
		.entry_valid (entry_valid),
		.occ_count   (occ_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (store_fire && (cmd_s1.action == ACT_GET)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_fire && (cmd_s1.action == ACT_GET)) begin
			rsp_q <= store_rsp;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = rsp_q.hit;
	assign read_value = rsp_q.read_value;

	// The occupancy counter tracks the number of valid entries exactly.
	`LKV_ASSERT(a_occ_matches_valid, clk, arst_n, $countones(entry_valid) == int'(occ_count))
	// Occupancy never exceeds the number of physical entries.
	`LKV_ASSERT(a_occ_bounded, clk, arst_n, int'(occ_count) <= ENTRIES)
	// A get that fires always leaves a result beat in the output register.
	`LKV_ASSERT_NEXT(a_get_gives_beat, clk, arst_n, store_fire && (cmd_s1.action == ACT_GET), out_valid_q)
	// The input side is held back only by an item already waiting.
	`LKV_ASSERT(a_stall_needs_item, clk, arst_n, !in_stall || valid_s1)

endmodule

### bench/lru_key_value_cache_top_test.sv
// Self-checking testbench for the LRU key-value cache: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module lru_key_value_cache_top_test;
	import lkv_pkg::*;

	// A directed row either sends one command beat or rewrites the capacity register.
	// For a capacity row the new capacity sits in the low bits of the value column.
	typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_e;

	typedef struct packed {
		row_kind_e        kind;
		logic             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic             typed;
		logic             want_hit;
		logic [VAL_W-1:0] want_val;
	} script_row_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             action     = ACT_GET;
	logic [KEY_W-1:0] key        = '0;
	logic [VAL_W-1:0] value      = '0;
	logic             out_stall  = 1'b0;
	logic             cfg_valid  = 1'b0;
	logic [CAP_W-1:0] cfg_data   = '0;
	logic             in_stall;
	logic             out_valid;
	logic             hit;
	logic [VAL_W-1:0] read_value;
	logic             cfg_ready;

	// Shadow copy of the cache, kept in step with every accepted command beat.
	bit [KEY_W-1:0]  line_key [ENTRIES];
	bit [VAL_W-1:0]  line_val [ENTRIES];
	bit              line_live [ENTRIES];
	bit [RANK_W-1:0] line_rank [ENTRIES];
	int              live_count = 0;
	bit [CAP_W-1:0]  cap_reg    = CAP_RESET;

	// Lookups whose response beat has not arrived yet, oldest first.
	rsp_t pending_reads [$];
	int   mismatch_count = 0;

	// Sender pacing: with gaps_on set, bursts of back-to-back beats separated by idle gaps.
	bit gaps_on    = 1'b1;
	int burst_left = 0;

	// Receiver stall pattern: a mode is held for a random span of cycles.
	int stall_mode = 0;
	int stall_span = 0;

	// Directed part. After reset every get misses; then the extreme keys and values
	// go in, an update of a stored key, a capacity lowered below the occupancy,
	// capacity zero (acts as one), capacity above the entry count (clamps) and
	// a put of a stored key at full capacity, which must not evict anything.
	script_row_t directed_rows [28] = '{
		'{ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ITEM, ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ITEM, ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{ROW_ITEM, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{ROW_ITEM, ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A},
		'{ROW_CAP,  ACT_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0011, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ITEM, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_CAP,  ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0011, 32'h0000_0022, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0033, 32'h0000_0033, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0011, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_CAP,  ACT_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0044, 32'h0000_0044, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0055, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0044, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0033, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_CAP,  ACT_GET, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_PUT, 32'h0000_0066, 32'hDEAD_0066, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0066, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
	};

	// Capacities of the random phases; the last phase picks one at random.
	int phase_caps [8] = '{16, 1, 2, 31, 0, 5, 17, 8};

	lru_key_value_cache_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// Moves entry e to the front of the recency order; entries that were more
	// recent than it slide back by one.
	function automatic void promote_entry(int e);
		for (int i = 0; i < ENTRIES; i++) begin
			if (line_live[i] && i != e && line_rank[i] < line_rank[e]) begin
				line_rank[i]++;
			end
		end
		line_rank[e] = '0;
	endfunction

	// Appends an expected response beat behind the ones already waiting.
	function automatic void queue_rsp(rsp_t r);
		pending_reads = {pending_reads, r};
	endfunction

	// Applies one accepted command to the shadow cache. A get always yields a
	// response; a put never does.
	task automatic cache_apply(input logic act, input bit [KEY_W-1:0] k,
			input bit [VAL_W-1:0] v, output bit gives, output rsp_t r);
		int found;
		int slot;
		int victim;
		int limit;
		found  = -1;
		slot   = -1;
		victim = -1;
		gives  = 1'b0;
		r.hit        = 1'b0;
		r.read_value = MISS_VALUE;
		// The capacity register is clamped into one to ENTRIES.
		if (cap_reg == 0) begin
			limit = 1;
		end else if (cap_reg > ENTRIES) begin
			limit = ENTRIES;
		end else begin
			limit = cap_reg;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (found < 0 && line_live[i] && line_key[i] == k) begin
				found = i;
			end
		end
		if (act == ACT_GET) begin
			gives = 1'b1;
			if (found >= 0) begin
				r.hit        = 1'b1;
				r.read_value = line_val[found];
				promote_entry(found);
			end
		end else if (found >= 0) begin
			// Update in place: never evicts, only the value and recency change.
			line_val[found] = v;
			promote_entry(found);
		end else if (live_count < limit) begin
			// Room left: take the lowest free entry and age everything else.
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && !line_live[i]) begin
					slot = i;
				end
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (line_live[i]) begin
					line_rank[i]++;
				end
			end
			line_live[slot] = 1'b1;
			line_key[slot]  = k;
			line_val[slot]  = v;
			line_rank[slot] = '0;
			live_count++;
		end else begin
			// Full, or capacity was lowered under the occupancy: overwrite the
			// least recent entry and keep the occupancy as it is.
			for (int i = 0; i < ENTRIES; i++) begin
				if (line_live[i] && (victim < 0 || line_rank[i] > line_rank[victim])) begin
					victim = i;
				end
			end
			line_key[victim] = k;
			line_val[victim] = v;
			promote_entry(victim);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t ns", what, got, want, $time);
		mismatch_count++;
	endtask

	// Sends one command beat, holding it steady while the block stalls. On
	// acceptance the shadow cache is updated and, for a get, the expected
	// response is queued. A typed row overrides the predicted response.
	task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input logic typed, input logic want_hit,
			input logic [VAL_W-1:0] want_val);
		bit   gives;
		rsp_t r;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (in_stall);
		cache_apply(act, k, v, gives, r);
		if (gives) begin
			if (typed) begin
				r.hit        = want_hit;
				r.read_value = want_val;
			end
			queue_rsp(r);
		end
	endtask

	// Stops sending and waits until every queued response beat has arrived,
	// then waits out the tail argument so that a trailing put has settled.
	// A clock edge always passes before it returns, so in_valid never gets two
	// assignments in one time step.
	task automatic settle(input int tail);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reads.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	// Writes the capacity register; callers make sure the block is idle.
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = c;
	endtask

	// Receiver side. Modes: never stall, stall now and then, stall mostly, and
	// long runs of stall and no stall.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(32, 256);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if ($urandom_range(0, 15) == 0) begin
					out_stall <= ~out_stall;
				end
			end
		endcase
	end

	// Response checker: every accepted response beat is matched against the
	// oldest lookup still waiting. Values are read at the edge, before any
	// nonblocking update of this step lands.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("response beat with no lookup waiting", read_value, 32'h0);
			end else begin
				want = pending_reads.pop_front();
				if (hit !== want.hit) begin
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				end
				if (read_value !== want.read_value) begin
					report_mismatch("read_value", read_value, want.read_value);
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases at several capacities.
	initial begin
		bit [KEY_W-1:0] key_pool [24];
		int             pool_size;
		int             cap;
		logic [KEY_W-1:0] k;
		logic           act;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CAP) begin
				settle(4);
				write_capacity(directed_rows[i].val[CAP_W-1:0]);
			end else begin
				send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].val,
					directed_rows[i].typed, directed_rows[i].want_hit,
					directed_rows[i].want_val);
			end
		end

		// Random phases. Keys come mostly from a small pool so that gets hit and
		// puts update or evict; one in ten is a fresh random key that will miss.
		for (int p = 0; p < 9; p++) begin
			cap = (p < 8) ? phase_caps[p] : $urandom_range(0, 31);
			gaps_on = (p % 3 != 0);
			pool_size = $urandom_range(2, 24);
			for (int j = 0; j < pool_size; j++) begin
				key_pool[j] = $urandom();
			end
			settle(4);
			write_capacity(cap[CAP_W-1:0]);
			for (int n = 0; n < 150; n++) begin
				// Halfway through, hold off until the pipeline has fully drained.
				if (n == 75) begin
					settle(0);
				end
				if ($urandom_range(0, 9) == 0) begin
					k = $urandom();
				end else begin
					k = key_pool[$urandom_range(0, pool_size - 1)];
				end
				act = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
				send_item(act, k, $urandom(), 1'b0, 1'b0, '0);
			end
		end

		settle(8);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: a hung handshake or a response that never arrives ends here.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lkv_store.sv
rtl/core/lru_key_value_cache_top.sv
bench/lru_key_value_cache_top_test.sv
